>>> hdl/ufew_pkg.sv
// ----------------------------------------------------------------------------
// ufew_pkg
// Shared types and constants for the union-find edge widening core.
// ----------------------------------------------------------------------------
package ufew_pkg;

  localparam int unsigned SPEED_W   = 32;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned RANK_W    = 4;
  localparam int unsigned VTX_IN_W  = 10;
  localparam int unsigned VCNT_W    = 11;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd1;

  // operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    ALU_EQ,     // flag = a == b
    ALU_LT,     // flag = a < b
    ALU_WIDEN,  // res  = sat(a * 1.5)
    ALU_INC     // res  = 16-bit saturating a + 1
  } alu_op_e;

  typedef struct packed {
    alu_op_e            op;
    logic [SPEED_W-1:0] a;
    logic [SPEED_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [SPEED_W-1:0] res;
    logic               flag;
  } alu_rsp_t;

endpackage

>>> hdl/ufew_alu.sv
// ----------------------------------------------------------------------------
// ufew_alu
// Shared compare / widen / increment unit, one operation per cycle.
// ----------------------------------------------------------------------------
module ufew_alu (
  input  ufew_pkg::alu_req_t req_i,
  output ufew_pkg::alu_rsp_t rsp_o
);
  import ufew_pkg::*;

  logic [SPEED_W:0]   wide_sum;
  logic [COUNT_W-1:0] cnt;

  // floor(3a/2) = a + floor(a/2)
  assign wide_sum = {1'b0, req_i.a} + {2'b00, req_i.a[SPEED_W-1:1]};
  assign cnt      = req_i.a[COUNT_W-1:0];

  always_comb begin
    rsp_o = '0;
    unique case (req_i.op)
      ALU_EQ: begin
        rsp_o.flag = (req_i.a == req_i.b);
      end
      ALU_LT: begin
        rsp_o.flag = (req_i.a < req_i.b);
      end
      ALU_WIDEN: begin
        rsp_o.res = wide_sum[SPEED_W] ? '1 : wide_sum[SPEED_W-1:0];
      end
      ALU_INC: begin
        rsp_o.res = {{(SPEED_W-COUNT_W){1'b0}},
                     ((cnt == '1) ? cnt : cnt + 1'b1)};
      end
      default: begin
        rsp_o = '0;
      end
    endcase
  end

endmodule

>>> hdl/ufew_forest_ram.sv
// ----------------------------------------------------------------------------
// ufew_forest_ram
// Forest store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ufew_forest_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 14
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/kruskal_union_find_edge_widen_core.sv
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_widen_core
// Kruskal edge acceptance over a union-find forest (union by rank, path
// halving) with 1.5x widening of slow joined edges.
// ----------------------------------------------------------------------------
// Usage: one word in, one word out, always. After reset the core sweeps the
// forest store (in_ready_o low) so every vertex is its own root of rank
// zero; a clear word (func 0) runs the same sweep and then returns an
// all-zero result. An edge word runs both find walks and, when the roots
// differ, the union; a joined edge below the speed limit is then widened
// and counted. An edge with a bad vertex goes straight to the result. Each
// halving step of a find walk is one read of the parent store followed by a
// read of the grandparent, with the halving write overlapped on the next
// read. Union, the speed compare, the widen and the count update all share
// one arithmetic unit, one operation per cycle. Edges are expected
// in nondecreasing cost order; the core does not check it. Configuration is
// taken at any time via cfg_* (index 0 speed limit, 1 vertex count), but
// should only be written while the core is idle. A finished result sits in
// the output register, and the next word may be accepted meanwhile.
// ----------------------------------------------------------------------------
module kruskal_union_find_edge_widen_core #(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ufew_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ufew_pkg::SPEED_W-1:0]       cfg_data_i,
  // input words
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               func_i,
  input  logic [ufew_pkg::VTX_IN_W-1:0]      from_vertex_i,
  input  logic [ufew_pkg::VTX_IN_W-1:0]      to_vertex_i,
  input  logic [ufew_pkg::SPEED_W-1:0]       edge_speed_i,
  input  logic [ufew_pkg::SPEED_W-1:0]       edge_cost_i,
  // result words
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               joined_o,
  output logic                               widened_o,
  output logic                               bad_vertex_o,
  output logic [ufew_pkg::SPEED_W-1:0]       speed_out_o,
  output logic [ufew_pkg::SPEED_W-1:0]       cost_out_o,
  output logic [ufew_pkg::COUNT_W-1:0]       widened_total_o
);
  import ufew_pkg::*;

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned DW = RANK_W + VW;
  localparam logic [VW-1:0] LAST_IDX = VW'(MAX_VERTICES - 1);

  typedef enum logic [3:0] {
    S_SWEEP,   // clearing pass over the forest store
    S_IDLE,
    S_FRD,     // first read of the walk
    S_FCHK,    // parent of v in hand: root or halve
    S_FHALVE,  // grandparent in hand: halving write
    S_UCMP,    // roots equal?
    S_URANK,   // rank order, link loser under winner
    S_UEQR,    // equal ranks bump the winner
    S_WCMP,    // speed below limit?
    S_WMUL,    // speed * 1.5
    S_WCNT,    // widened count + 1
    S_EMIT
  } state_e;

  state_e state_q;

  // configuration
  logic [SPEED_W-1:0] speed_limit_q;
  logic [VCNT_W-1:0]  vertex_count_q;

  // latched word
  logic               func_q;
  logic [VW-1:0]      b_q;
  logic [SPEED_W-1:0] speed_q;
  logic [SPEED_W-1:0] cost_q;
  logic               bad_q;

  // sequencer working registers
  logic [VW-1:0]      sweep_q;
  logic               clr_q;
  logic               phase_q;
  logic [VW-1:0]      v_q;
  logic [RANK_W-1:0]  rank_v_q;
  logic [VW-1:0]      ra_q, rb_q, win_q;
  logic [RANK_W-1:0]  rka_q, rkb_q, rkw_q, rkl_q;
  logic               jn_q, wd_q;
  logic [SPEED_W-1:0] res_speed_q;
  logic [COUNT_W-1:0] count_q;

  // result register
  logic               out_valid_q;
  logic               joined_q, widened_q, bad_vertex_q;
  logic [SPEED_W-1:0] speed_out_q, cost_out_q;
  logic [COUNT_W-1:0] total_q;

  // forest store port
  logic          mem_we, mem_re;
  logic [VW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;
  logic [VW-1:0]     rd_parent;
  logic [RANK_W-1:0] rd_rank;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic in_acc, bad_now;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  // endpoint must lie below both the vertex count and the store depth
  assign bad_now = ({1'b0, from_vertex_i} >= vertex_count_q) ||
                   ({1'b0, to_vertex_i}   >= vertex_count_q) ||
                   (32'(from_vertex_i) >= MAX_VERTICES)      ||
                   (32'(to_vertex_i)   >= MAX_VERTICES);

  assign rd_parent = mem_rdata[VW-1:0];
  assign rd_rank   = mem_rdata[VW +: RANK_W];

  ufew_forest_ram #(
    .DEPTH (MAX_VERTICES),
    .AW    (VW),
    .DW    (DW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ufew_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // shared unit operand selection
  always_comb begin
    alu_req = '0;
    alu_req.op = ALU_EQ;
    unique case (state_q)
      S_FCHK: begin
        alu_req.a = 32'(rd_parent);
        alu_req.b = 32'(v_q);
      end
      S_UCMP: begin
        alu_req.a = 32'(ra_q);
        alu_req.b = 32'(rb_q);
      end
      S_URANK: begin
        alu_req.op = ALU_LT;
        alu_req.a  = 32'(rka_q);
        alu_req.b  = 32'(rkb_q);
      end
      S_UEQR: begin
        alu_req.a = 32'(rkw_q);
        alu_req.b = 32'(rkl_q);
      end
      S_WCMP: begin
        alu_req.op = ALU_LT;
        alu_req.a  = speed_q;
        alu_req.b  = speed_limit_q;
      end
      S_WMUL: begin
        alu_req.op = ALU_WIDEN;
        alu_req.a  = speed_q;
      end
      S_WCNT: begin
        alu_req.op = ALU_INC;
        alu_req.a  = 32'(count_q);
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // store port: sweep, halving and union writes share the one write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_q)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = {{RANK_W{1'b0}}, sweep_q};
      end
      S_FRD: begin
        mem_re    = 1'b1;
        mem_raddr = v_q;
      end
      S_FCHK: begin
        if (!alu_rsp.flag) begin
          mem_re    = 1'b1;
          mem_raddr = rd_parent;
        end else if (!phase_q) begin
          // first root found: start the second walk at once
          mem_re    = 1'b1;
          mem_raddr = b_q;
        end
      end
      S_FHALVE: begin
        // v skips to its grandparent, and the walk goes on from there
        mem_we    = 1'b1;
        mem_waddr = v_q;
        mem_wdata = {rank_v_q, rd_parent};
        mem_re    = 1'b1;
        mem_raddr = rd_parent;
      end
      S_URANK: begin
        mem_we = 1'b1;
        if (alu_rsp.flag) begin
          mem_waddr = ra_q;
          mem_wdata = {rka_q, rb_q};
        end else begin
          mem_waddr = rb_q;
          mem_wdata = {rkb_q, ra_q};
        end
      end
      S_UEQR: begin
        if (alu_rsp.flag && (rkw_q != RANK_MAX)) begin
          mem_we    = 1'b1;
          mem_waddr = win_q;
          mem_wdata = {rkw_q + 1'b1, win_q};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_SWEEP;
      speed_limit_q  <= '0;
      vertex_count_q <= '0;
      func_q         <= 1'b0;
      b_q            <= '0;
      speed_q        <= '0;
      cost_q         <= '0;
      bad_q          <= 1'b0;
      sweep_q        <= '0;
      clr_q          <= 1'b0;
      phase_q        <= 1'b0;
      v_q            <= '0;
      rank_v_q       <= '0;
      ra_q           <= '0;
      rb_q           <= '0;
      win_q          <= '0;
      rka_q          <= '0;
      rkb_q          <= '0;
      rkw_q          <= '0;
      rkl_q          <= '0;
      jn_q           <= 1'b0;
      wd_q           <= 1'b0;
      res_speed_q    <= '0;
      count_q        <= '0;
      out_valid_q    <= 1'b0;
      joined_q       <= 1'b0;
      widened_q      <= 1'b0;
      bad_vertex_q   <= 1'b0;
      speed_out_q    <= '0;
      cost_out_q     <= '0;
      total_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_SPEED_LIMIT:  speed_limit_q  <= cfg_data_i;
          CFG_VERTEX_COUNT: vertex_count_q <= cfg_data_i[VCNT_W-1:0];
          default: ;
        endcase
      end

      // S_EMIT reloads the result register itself
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_SWEEP: begin
          if (sweep_q == LAST_IDX) begin
            sweep_q <= '0;
            clr_q   <= 1'b0;
            state_q <= clr_q ? S_EMIT : S_IDLE;
          end else begin
            sweep_q <= sweep_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            func_q      <= func_i;
            b_q         <= VW'(to_vertex_i);
            speed_q     <= edge_speed_i;
            cost_q      <= edge_cost_i;
            bad_q       <= bad_now;
            jn_q        <= 1'b0;
            wd_q        <= 1'b0;
            res_speed_q <= edge_speed_i;
            v_q         <= VW'(from_vertex_i);
            phase_q     <= 1'b0;
            if (!func_i) begin
              count_q <= '0;
              sweep_q <= '0;
              clr_q   <= 1'b1;
              state_q <= S_SWEEP;
            end else if (bad_now) begin
              state_q <= S_EMIT;
            end else begin
              state_q <= S_FRD;
            end
          end
        end
        S_FRD: begin
          state_q <= S_FCHK;
        end
        S_FCHK: begin
          if (alu_rsp.flag) begin
            if (!phase_q) begin
              ra_q    <= v_q;
              rka_q   <= rd_rank;
              v_q     <= b_q;
              phase_q <= 1'b1;
            end else begin
              rb_q    <= v_q;
              rkb_q   <= rd_rank;
              state_q <= S_UCMP;
            end
          end else begin
            rank_v_q <= rd_rank;
            state_q  <= S_FHALVE;
          end
        end
        S_FHALVE: begin
          v_q     <= rd_parent;
          state_q <= S_FCHK;
        end
        S_UCMP: begin
          state_q <= alu_rsp.flag ? S_EMIT : S_URANK;
        end
        S_URANK: begin
          jn_q <= 1'b1;
          if (alu_rsp.flag) begin
            win_q <= rb_q;
            rkw_q <= rkb_q;
            rkl_q <= rka_q;
          end else begin
            win_q <= ra_q;
            rkw_q <= rka_q;
            rkl_q <= rkb_q;
          end
          state_q <= S_UEQR;
        end
        S_UEQR: begin
          state_q <= S_WCMP;
        end
        S_WCMP: begin
          state_q <= alu_rsp.flag ? S_WMUL : S_EMIT;
        end
        S_WMUL: begin
          res_speed_q <= alu_rsp.res;
          wd_q        <= 1'b1;
          state_q     <= S_WCNT;
        end
        S_WCNT: begin
          count_q <= alu_rsp.res[COUNT_W-1:0];
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            joined_q     <= func_q & jn_q;
            widened_q    <= func_q & wd_q;
            bad_vertex_q <= func_q & bad_q;
            speed_out_q  <= func_q ? res_speed_q : '0;
            cost_out_q   <= func_q ? cost_q : '0;
            total_q      <= count_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign joined_o        = joined_q;
  assign widened_o       = widened_q;
  assign bad_vertex_o    = bad_vertex_q;
  assign speed_out_o     = speed_out_q;
  assign cost_out_o      = cost_out_q;
  assign widened_total_o = total_q;

  // a widened word must be a joined one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!widened_o || joined_o))
    else $error("widened without join");

  // a bad vertex never joins
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_vertex_o) |-> (!joined_o && !widened_o))
    else $error("bad vertex joined");

  // a clear word starts the sweep with the count zeroed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !func_i) |=> (state_q == S_SWEEP && count_q == '0))
    else $error("clear did not start sweep");

  // the forest store is never written while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("store write while idle");

endmodule
